// File: rtl/core/assert_macros.svh
// Assertion helpers for the RTL; clock and reset come from the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define AOEMA_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("aoema check failed");

// Next-cycle implication, checked outside reset.
`define AOEMA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("aoema check failed");

`endif

// File: rtl/core/aoema_pkg.sv
package aoema_pkg;

   localparam int SAMPLE_W = 16;
   localparam int AVG_W    = 32;
   localparam int FRAC_W   = 16;
   localparam int ALPHA_W  = 17;
   localparam int CSR_IDX_W = 1;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;
   localparam logic [SAMPLE_W-1:0] OFFSET_RESET = '0;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_OFFSET = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_ALPHA  = 1'b1;

   typedef enum logic [1:0] {
      CASE_Y_CORR = 2'd0,
      CASE_X_CORR = 2'd1,
      CASE_Z_CORR = 2'd2
   } orient_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] x;
      logic signed [SAMPLE_W-1:0] y;
      logic signed [SAMPLE_W-1:0] z;
   } sample_type;

   typedef struct packed {
      orient_type orient;
      sample_type sample;
   } sel_type;

   // True when 0 < v < 2048.
   function automatic logic low_g(input logic signed [SAMPLE_W-1:0] v);
      logic result;
      result = !v[SAMPLE_W-1] && (v != '0) && (v[SAMPLE_W-2:11] == '0);
      return result;
   endfunction

   // v - off, clipped to the signed sample range.
   function automatic logic signed [SAMPLE_W-1:0] sat_sub(
      input logic signed [SAMPLE_W-1:0] v,
      input logic signed [SAMPLE_W-1:0] off);
      logic signed [SAMPLE_W:0] diff;
      logic signed [SAMPLE_W-1:0] result;
      diff = {v[SAMPLE_W-1], v} - {off[SAMPLE_W-1], off};
      if (diff[SAMPLE_W] == diff[SAMPLE_W-1]) begin
         result = diff[SAMPLE_W-1:0];
      end else if (diff[SAMPLE_W]) begin
         result = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         result = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
      return result;
   endfunction

endpackage

// File: rtl/core/aoema_if.sv
interface aoema_req_if;
   logic valid;
   logic ready;
   logic signed [aoema_pkg::SAMPLE_W-1:0] x_sample;
   logic signed [aoema_pkg::SAMPLE_W-1:0] y_sample;
   logic signed [aoema_pkg::SAMPLE_W-1:0] z_sample;

   modport source (output valid, x_sample, y_sample, z_sample, input ready);
   modport sink   (input valid, x_sample, y_sample, z_sample, output ready);
endinterface

interface aoema_rsp_if;
   logic valid;
   logic ready;
   logic signed [aoema_pkg::AVG_W-1:0] x_smoothed;
   logic signed [aoema_pkg::AVG_W-1:0] y_smoothed;
   logic signed [aoema_pkg::AVG_W-1:0] z_smoothed;
   logic [1:0] orientation_case;

   modport source (output valid, x_smoothed, y_smoothed, z_smoothed, orientation_case,
                   input ready);
   modport sink   (input valid, x_smoothed, y_smoothed, z_smoothed, orientation_case,
                   output ready);
endinterface

interface aoema_csr_if;
   logic valid;
   logic ready;
   logic [aoema_pkg::CSR_IDX_W-1:0] index;
   logic [aoema_pkg::ALPHA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/accel_offset_ema_filter_top.sv
// Req word -> s1_ff -> average registers, which drive the rsp word.
// Throughput: one word per cycle unless rsp_ch stalls, set by the per-axis
//   average loop (subtract, one 33x17 multiply and an add per lane).
// Reset (synchronous, active high): pipeline empty, averages zero,
//   normal_axis_offset zero, filter_alpha one (65536).
`include "assert_macros.svh"

module accel_offset_ema_filter_top (
   input  logic        clock,
   input  logic        reset,
   aoema_req_if.sink   req_ch,
   aoema_rsp_if.source rsp_ch,
   aoema_csr_if.sink   csr_ch
);

   logic signed [aoema_pkg::SAMPLE_W-1:0] offset_ff;
   logic [aoema_pkg::ALPHA_W-1:0]         alpha_ff;

   logic                   s1_valid_ff;
   aoema_pkg::sel_type     s1_ff;
   aoema_pkg::sel_type     s1_in;
   logic                   out_valid_ff;
   aoema_pkg::orient_type  orient_ff;

   logic                   out_advance;
   logic                   s1_advance;
   logic                   alpha_full;
   logic [aoema_pkg::FRAC_W-1:0] alpha_frac;
   aoema_pkg::sample_type  req_sample;

   logic                               full_stall;
   logic                               full_advance;
   logic signed [aoema_pkg::AVG_W-1:0] x_full_target;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= aoema_pkg::OFFSET_RESET;
         alpha_ff  <= aoema_pkg::ALPHA_ONE;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            aoema_pkg::CSR_NORMAL_OFFSET: offset_ff <= csr_ch.data[aoema_pkg::SAMPLE_W-1:0];
            aoema_pkg::CSR_FILTER_ALPHA:  alpha_ff  <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // anything at or above one weights the new sample fully
   assign alpha_full = alpha_ff[aoema_pkg::ALPHA_W-1];
   assign alpha_frac = alpha_ff[aoema_pkg::FRAC_W-1:0];

   assign req_sample.x = req_ch.x_sample;
   assign req_sample.y = req_ch.y_sample;
   assign req_sample.z = req_ch.z_sample;

   aoema_sel u_sel (
      .sample (req_sample),
      .offset (offset_ff),
      .sel    (s1_in)
   );

   // the average registers double as the output register
   assign out_advance  = !out_valid_ff || rsp_ch.ready;
   assign s1_advance   = s1_valid_ff && out_advance;
   assign req_ch.ready = !s1_valid_ff || out_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ch.ready) begin
            s1_valid_ff <= req_ch.valid;
         end
         if (out_advance) begin
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         s1_ff <= s1_in;
      end
      if (s1_advance) begin
         orient_ff <= s1_ff.orient;
      end
   end

   aoema_lane u_lane_x (
      .clock      (clock),
      .reset      (reset),
      .advance    (s1_advance),
      .sample     (s1_ff.sample.x),
      .alpha_full (alpha_full),
      .alpha_frac (alpha_frac),
      .average    (rsp_ch.x_smoothed)
   );

   aoema_lane u_lane_y (
      .clock      (clock),
      .reset      (reset),
      .advance    (s1_advance),
      .sample     (s1_ff.sample.y),
      .alpha_full (alpha_full),
      .alpha_frac (alpha_frac),
      .average    (rsp_ch.y_smoothed)
   );

   aoema_lane u_lane_z (
      .clock      (clock),
      .reset      (reset),
      .advance    (s1_advance),
      .sample     (s1_ff.sample.z),
      .alpha_full (alpha_full),
      .alpha_frac (alpha_frac),
      .average    (rsp_ch.z_smoothed)
   );

   assign rsp_ch.valid            = out_valid_ff;
   assign rsp_ch.orientation_case = orient_ff;

   assign full_stall    = s1_valid_ff && out_valid_ff && !rsp_ch.ready;
   assign full_advance  = s1_advance && alpha_full;
   assign x_full_target = {s1_ff.sample.x, {aoema_pkg::FRAC_W{1'b0}}};

   `AOEMA_ASSERT_NOW(a_no_accept_when_full, req_ch.ready, !full_stall)
   `AOEMA_ASSERT_NEXT(a_stage_held, s1_valid_ff && !out_advance, s1_valid_ff)
   `AOEMA_ASSERT_NEXT(a_full_alpha, full_advance, rsp_ch.x_smoothed == $past(x_full_target))

endmodule

// File: rtl/core/aoema_sel.sv
module aoema_sel (
   input  aoema_pkg::sample_type                 sample,
   input  logic signed [aoema_pkg::SAMPLE_W-1:0] offset,
   output aoema_pkg::sel_type                    sel
);

   logic x_low;
   logic z_low;

   assign x_low = aoema_pkg::low_g(sample.x);
   assign z_low = aoema_pkg::low_g(sample.z);

   always_comb begin
      sel.sample = sample;
      if (x_low && z_low) begin
         sel.orient   = aoema_pkg::CASE_Y_CORR;
         sel.sample.y = aoema_pkg::sat_sub(sample.y, offset);
      end else if (z_low) begin
         sel.orient   = aoema_pkg::CASE_X_CORR;
         sel.sample.x = aoema_pkg::sat_sub(sample.x, offset);
      end else begin
         sel.orient   = aoema_pkg::CASE_Z_CORR;
         sel.sample.z = aoema_pkg::sat_sub(sample.z, offset);
      end
   end

endmodule

// File: rtl/core/aoema_lane.sv
module aoema_lane (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance,
   input  logic signed [aoema_pkg::SAMPLE_W-1:0] sample,
   input  logic                                  alpha_full,
   input  logic [aoema_pkg::FRAC_W-1:0]          alpha_frac,
   output logic signed [aoema_pkg::AVG_W-1:0]    average
);

   localparam int DIFF_W = aoema_pkg::AVG_W + 1;
   localparam int PROD_W = DIFF_W + aoema_pkg::FRAC_W + 1;
   localparam int STEP_W = PROD_W - aoema_pkg::FRAC_W;

   logic signed [aoema_pkg::AVG_W-1:0] avg_ff;
   logic signed [aoema_pkg::AVG_W-1:0] avg_in;
   logic signed [aoema_pkg::AVG_W-1:0] target;
   logic signed [DIFF_W-1:0]           diff;
   logic signed [PROD_W-1:0]           prod;
   logic signed [PROD_W-1:0]           prod_rnd;
   logic signed [STEP_W-1:0]           step;
   logic signed [STEP_W-1:0]           sum;

   // avg + round(alpha * (target - avg) / 2^16), halves up; target if alpha_full
   assign target   = {sample, {aoema_pkg::FRAC_W{1'b0}}};
   assign diff     = {target[aoema_pkg::AVG_W-1], target} - {avg_ff[aoema_pkg::AVG_W-1], avg_ff};
   assign prod     = PROD_W'(diff) * PROD_W'($signed({1'b0, alpha_frac}));
   assign prod_rnd = prod + PROD_W'(1 << (aoema_pkg::FRAC_W - 1));
   assign step     = prod_rnd[PROD_W-1:aoema_pkg::FRAC_W];
   assign sum      = {{(STEP_W - aoema_pkg::AVG_W){avg_ff[aoema_pkg::AVG_W-1]}}, avg_ff} + step;
   assign avg_in   = alpha_full ? target : sum[aoema_pkg::AVG_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_ff <= '0;
      end else if (advance) begin
         avg_ff <= avg_in;
      end
   end

   assign average = avg_ff;

endmodule

// File: verif/accel_offset_ema_filter_top_tb.sv
module accel_offset_ema_filter_top_tb;

   localparam int SAMPLE_W  = aoema_pkg::SAMPLE_W;
   localparam int AVG_W     = aoema_pkg::AVG_W;
   localparam int ALPHA_W   = aoema_pkg::ALPHA_W;
   localparam int CSR_IDX_W = aoema_pkg::CSR_IDX_W;

   localparam int WATCHDOG_LIMIT  = 1000;
   localparam int PHASES          = 8;
   localparam int WORDS_PER_PHASE = 60;
   localparam int SETTLE_CYCLES   = 4;
   localparam int HOLD_OFF_CYCLES = 64;
   localparam int MAX_REPORTS     = 10;

   typedef struct packed {
      logic [AVG_W-1:0]      x;
      logic [AVG_W-1:0]      y;
      logic [AVG_W-1:0]      z;
      aoema_pkg::orient_type orient;
   } smoothed_type;

   typedef struct packed {
      logic         known;
      smoothed_type want;
   } offered_type;

   typedef struct packed {
      logic                  is_reg;
      logic [CSR_IDX_W-1:0]  idx;
      logic [ALPHA_W-1:0]    wdata;
      aoema_pkg::sample_type smp;
      logic                  known;
      smoothed_type          want;
   } step_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   aoema_req_if req_ch ();
   aoema_rsp_if rsp_ch ();
   aoema_csr_if csr_ch ();

   accel_offset_ema_filter_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state: register copies and the three running averages
   logic signed [SAMPLE_W-1:0] offset_cfg;
   logic [ALPHA_W-1:0]         alpha_cfg;
   logic [AVG_W-1:0]           x_avg, y_avg, z_avg;

   smoothed_type pending_smoothed[$];
   offered_type  offered_info[$];

   int  n_samples, n_results, n_writes, n_mismatch, idle_cycles;
   int  case_seen[3];
   bit  steady;
   int  hold_request;

   function automatic logic in_low_g(logic signed [SAMPLE_W-1:0] v);
      return (v > 0) && (v < 2048);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] remove_offset(
      logic signed [SAMPLE_W-1:0] v, logic signed [SAMPLE_W-1:0] off);
      int d;
      d = int'(v) - int'(off);
      if (d > 32767) return SAMPLE_W'(32767);
      if (d < -32768) return SAMPLE_W'(-32768);
      return SAMPLE_W'(d);
   endfunction

   function automatic logic [AVG_W-1:0] ema_next(logic [AVG_W-1:0] avg,
      logic signed [SAMPLE_W-1:0] v, logic [ALPHA_W-1:0] alpha);
      longint a;
      longint acc;
      a = (alpha > aoema_pkg::ALPHA_ONE) ? 65536 : alpha;
      acc = a * (longint'(v) <<< 16) + (65536 - a) * longint'($signed(avg));
      // round halves up, then floor
      acc = (acc + 32768) >>> 16;
      return AVG_W'(acc);
   endfunction

   function automatic smoothed_type filter_sample(aoema_pkg::sample_type s);
      aoema_pkg::sample_type c;
      smoothed_type r;
      c = s;
      if (in_low_g(s.x) && in_low_g(s.z)) begin
         r.orient = aoema_pkg::CASE_Y_CORR;
         c.y = remove_offset(s.y, offset_cfg);
      end else if (in_low_g(s.z)) begin
         r.orient = aoema_pkg::CASE_X_CORR;
         c.x = remove_offset(s.x, offset_cfg);
      end else begin
         r.orient = aoema_pkg::CASE_Z_CORR;
         c.z = remove_offset(s.z, offset_cfg);
      end
      x_avg = ema_next(x_avg, c.x, alpha_cfg);
      y_avg = ema_next(y_avg, c.y, alpha_cfg);
      z_avg = ema_next(z_avg, c.z, alpha_cfg);
      r.x = x_avg;
      r.y = y_avg;
      r.z = z_avg;
      return r;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] draw_axis(bit lean_low_g);
      int pick;
      pick = $urandom_range(0, 9);
      if (lean_low_g && pick < 5) return SAMPLE_W'($urandom_range(1, 2047));
      if (pick == 5) begin
         case ($urandom_range(0, 7))
            0: return SAMPLE_W'(0);
            1: return SAMPLE_W'(1);
            2: return SAMPLE_W'(2047);
            3: return SAMPLE_W'(2048);
            4: return SAMPLE_W'(-1);
            5: return SAMPLE_W'(-2048);
            6: return SAMPLE_W'(32767);
            default: return SAMPLE_W'(-32768);
         endcase
      end
      return SAMPLE_W'($urandom);
   endfunction

   function automatic step_row_type row_reg(logic [CSR_IDX_W-1:0] idx, int data);
      step_row_type r;
      r = '0;
      r.is_reg = 1'b1;
      r.idx = idx;
      r.wdata = ALPHA_W'(data);
      return r;
   endfunction

   function automatic step_row_type row_smp(int x, int y, int z);
      step_row_type r;
      r = '0;
      r.smp.x = SAMPLE_W'(x);
      r.smp.y = SAMPLE_W'(y);
      r.smp.z = SAMPLE_W'(z);
      return r;
   endfunction

   function automatic step_row_type row_chk(int x, int y, int z, logic [AVG_W-1:0] ex,
      logic [AVG_W-1:0] ey, logic [AVG_W-1:0] ez, aoema_pkg::orient_type o);
      step_row_type r;
      r = row_smp(x, y, z);
      r.known = 1'b1;
      r.want.x = ex;
      r.want.y = ey;
      r.want.z = ez;
      r.want.orient = o;
      return r;
   endfunction

   task automatic send_sample(aoema_pkg::sample_type s, offered_type info);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      offered_info.push_back(info);
      req_ch.valid <= 1'b1;
      req_ch.x_sample <= s.x;
      req_ch.y_sample <= s.y;
      req_ch.z_sample <= s.z;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   // drop valid and wait until every pending word has come back
   task automatic settle_block();
      req_ch.valid <= 1'b0;
      while (pending_smoothed.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [ALPHA_W-1:0] data);
      settle_block();
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      aoema_pkg::sample_type s;
      smoothed_type guess, got, want;
      offered_type  info;
      bit           busy;
      if (reset) begin
         offset_cfg = aoema_pkg::OFFSET_RESET;
         alpha_cfg  = aoema_pkg::ALPHA_ONE;
         x_avg = '0;
         y_avg = '0;
         z_avg = '0;
         idle_cycles = 0;
      end else begin
         busy = 1'b0;
         if (csr_ch.valid && csr_ch.ready) begin
            busy = 1'b1;
            n_writes++;
            if (csr_ch.index == aoema_pkg::CSR_NORMAL_OFFSET)
               offset_cfg = csr_ch.data[SAMPLE_W-1:0];
            else if (csr_ch.index == aoema_pkg::CSR_FILTER_ALPHA)
               alpha_cfg = csr_ch.data;
         end
         if (req_ch.valid && req_ch.ready) begin
            busy = 1'b1;
            n_samples++;
            s.x = req_ch.x_sample;
            s.y = req_ch.y_sample;
            s.z = req_ch.z_sample;
            info = offered_info.pop_front();
            guess = filter_sample(s);
            case_seen[guess.orient]++;
            // hand-written expectations take precedence over the predictor
            pending_smoothed.push_back(info.known ? info.want : guess);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            busy = 1'b1;
            n_results++;
            got.x = rsp_ch.x_smoothed;
            got.y = rsp_ch.y_smoothed;
            got.z = rsp_ch.z_smoothed;
            got.orient = aoema_pkg::orient_type'(rsp_ch.orientation_case);
            if (pending_smoothed.size() == 0) begin
               n_mismatch++;
               if (n_mismatch <= MAX_REPORTS)
                  $display("unexpected word: x=%h y=%h z=%h case=%0d",
                           got.x, got.y, got.z, got.orient);
            end else begin
               want = pending_smoothed.pop_front();
               if (got !== want) begin
                  n_mismatch++;
                  if (n_mismatch <= MAX_REPORTS)
                     $display("word %0d: expected x=%h y=%h z=%h case=%0d, %s",
                              n_results, want.x, want.y, want.z, want.orient,
                              $sformatf("got x=%h y=%h z=%h case=%0d",
                                        got.x, got.y, got.z, got.orient));
               end
            end
         end
         idle_cycles = busy ? 0 : idle_cycles + 1;
      end
   end

   // result side: random stalls, one long hold-off on request
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if (hold_request > 0) begin
            stall = hold_request;
            hold_request = 0;
         end else begin
            stall = steady ? 0 : $urandom_range(0, 8);
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         @(negedge clock);
      end
   end

   initial begin
      wait (reset === 1'b0);
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("timeout: no handshake for %0d cycles, %0d words pending",
               WATCHDOG_LIMIT, pending_smoothed.size());
      $display("Verification failed");
      $finish;
   end

   initial begin
      step_row_type          dir_tbl[$];
      aoema_pkg::sample_type s;
      offered_type           blank;
      int                    oval, aval;

      req_ch.valid = 1'b0;
      req_ch.x_sample = '0;
      req_ch.y_sample = '0;
      req_ch.z_sample = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
      n_samples = 0;
      n_results = 0;
      n_writes = 0;
      n_mismatch = 0;
      idle_cycles = 0;
      case_seen = '{0, 0, 0};
      steady = 1'b0;
      hold_request = 0;
      blank = '0;

      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // alpha is one after reset, so each average equals the new sample
      dir_tbl = '{
         row_chk(100, 5, 100, 32'h0064_0000, 32'h0005_0000, 32'h0064_0000,
                 aoema_pkg::CASE_Y_CORR),
         row_chk(32767, -32768, -32768,
                 32'h7FFF_0000, 32'h8000_0000, 32'h8000_0000, aoema_pkg::CASE_Z_CORR),
         row_chk(-32768, 32767, 1,
                 32'h8000_0000, 32'h7FFF_0000, 32'h0001_0000, aoema_pkg::CASE_X_CORR),
         row_chk(2047, 0, 2047, 32'h07FF_0000, 32'h0000_0000, 32'h07FF_0000,
                 aoema_pkg::CASE_Y_CORR),
         row_chk(0, -1, 2048, 32'h0000_0000, 32'hFFFF_0000, 32'h0800_0000,
                 aoema_pkg::CASE_Z_CORR),
         row_chk(1, 1, 0, 32'h0001_0000, 32'h0001_0000, 32'h0000_0000,
                 aoema_pkg::CASE_Z_CORR),
         row_chk(2048, -2, 1, 32'h0800_0000, 32'hFFFE_0000, 32'h0001_0000,
                 aoema_pkg::CASE_X_CORR),
         row_reg(aoema_pkg::CSR_NORMAL_OFFSET, 32767),
         row_chk(5, -32768, 5, 32'h0005_0000, 32'h8000_0000, 32'h0005_0000,
                 aoema_pkg::CASE_Y_CORR),
         row_chk(-1, 0, -32768, 32'hFFFF_0000, 32'h0000_0000, 32'h8000_0000,
                 aoema_pkg::CASE_Z_CORR),
         row_chk(32767, 3, 2047, 32'h0000_0000, 32'h0003_0000, 32'h07FF_0000,
                 aoema_pkg::CASE_X_CORR),
         row_reg(aoema_pkg::CSR_NORMAL_OFFSET, -32768),
         row_chk(-5, 7, 1, 32'h7FFB_0000, 32'h0007_0000, 32'h0001_0000,
                 aoema_pkg::CASE_X_CORR),
         row_chk(1, 32767, 1, 32'h0001_0000, 32'h7FFF_0000, 32'h0001_0000,
                 aoema_pkg::CASE_Y_CORR),
         row_chk(0, 0, 32767, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_0000,
                 aoema_pkg::CASE_Z_CORR),
         // alpha zero holds every average
         row_reg(aoema_pkg::CSR_FILTER_ALPHA, 0),
         row_chk(-32768, -32768, -32768,
                 32'h0000_0000, 32'h0000_0000, 32'h7FFF_0000, aoema_pkg::CASE_Z_CORR),
         // alpha above one acts as one
         row_reg(aoema_pkg::CSR_FILTER_ALPHA, 'h1FFFF),
         row_chk(100, -100, 3000, 32'h0064_0000, 32'hFF9C_0000, 32'h7FFF_0000,
                 aoema_pkg::CASE_Z_CORR),
         row_reg(aoema_pkg::CSR_FILTER_ALPHA, 'h8000),
         row_smp(32767, -32768, 1),
         row_smp(-1, 1, 2047),
         row_smp(1, -1, -1),
         row_reg(aoema_pkg::CSR_FILTER_ALPHA, 1),
         row_smp(-32768, 32767, 2047),
         row_smp(2047, -3, 5)
      };

      foreach (dir_tbl[i]) begin
         if (dir_tbl[i].is_reg) write_reg(dir_tbl[i].idx, dir_tbl[i].wdata);
         else send_sample(dir_tbl[i].smp, '{dir_tbl[i].known, dir_tbl[i].want});
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin oval = 0;      aval = 'h10000; end
            1: begin oval = 32767;  aval = 'h8000;  end
            2: begin oval = -32768; aval = 1;       end
            3: begin oval = 2048;   aval = 'h1FFFF; end
            4: begin oval = $urandom; aval = $urandom_range(0, 'h10000); end
            5: begin oval = $urandom; aval = 0; end
            6: begin oval = $urandom; aval = $urandom_range('h10001, 'h1FFFF); end
            default: begin oval = $urandom; aval = $urandom_range(0, 'h1FFFF); end
         endcase
         write_reg(aoema_pkg::CSR_NORMAL_OFFSET, {1'($urandom), SAMPLE_W'(oval)});
         write_reg(aoema_pkg::CSR_FILTER_ALPHA, ALPHA_W'(aval));
         steady = (ph == 2) || (ph == 5);
         // back-pressure: receiver stalls long while words keep coming
         if (ph == 2) hold_request = HOLD_OFF_CYCLES;
         for (int k = 0; k < WORDS_PER_PHASE; k++) begin
            if (ph == 4 && k == WORDS_PER_PHASE / 2) settle_block();
            s.x = draw_axis(1'b1);
            s.y = draw_axis(1'b0);
            s.z = draw_axis(1'b1);
            send_sample(s, blank);
         end
      end
      steady = 1'b0;

      settle_block();
      $display("Ran %0d samples, %0d words checked, %0d register writes",
               n_samples, n_results, n_writes);
      $display("Orientation mix: Y %0d, X %0d, Z %0d; mismatches %0d",
               case_seen[aoema_pkg::CASE_Y_CORR], case_seen[aoema_pkg::CASE_X_CORR],
               case_seen[aoema_pkg::CASE_Z_CORR], n_mismatch);
      if (n_mismatch == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
